### design/emf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package emf_pkg;

  localparam logic [13:0] YEAR_MIN = 14'd1583;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // Number of register stages from the input transfer to the output register
  localparam int NSTG = 16;

  typedef struct packed {
    logic [2:0] mon;
    logic [4:0] dom;
  } date_t;

  // Turn a day of the year (January 1 is day 1) into month and day.
  // Covers January through June, which holds every feast date.
  function automatic date_t date_of(input logic [7:0] doy, input logic lp);
    logic [7:0] feb_end;
    logic [7:0] mar_end;
    logic [7:0] apr_end;
    logic [7:0] may_end;
    date_t      d;
    feb_end = 8'd59 + {7'd0, lp};
    mar_end = feb_end + 8'd31;
    apr_end = feb_end + 8'd61;
    may_end = feb_end + 8'd92;
    priority if (doy <= 8'd31) begin
      d.mon = 3'd1;
      d.dom = doy[4:0];
    end else if (doy <= feb_end) begin
      d.mon = 3'd2;
      d.dom = 5'(doy - 8'd31);
    end else if (doy <= mar_end) begin
      d.mon = 3'd3;
      d.dom = 5'(doy - feb_end);
    end else if (doy <= apr_end) begin
      d.mon = 3'd4;
      d.dom = 5'(doy - mar_end);
    end else if (doy <= may_end) begin
      d.mon = 3'd5;
      d.dom = 5'(doy - apr_end);
    end else begin
      d.mon = 3'd6;
      d.dom = 5'(doy - may_end);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### design/easter_and_movable_feasts_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one year per cycle unless the output stalls; sixteen pipeline stages,
// each holding one constant multiply or one short add/compare, set the depth.
// A stall at the output freezes the whole pipeline; in_ready drops only then.
// Reset (rst, synchronous) clears the stage valid bits; data registers keep garbage.
module easter_and_movable_feasts_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [13:0] year,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             leap,
  output logic [4:0]       easter_dom,
  output logic [2:0]       easter_mon,
  output logic [4:0]       carnival_dom,
  output logic [1:0]       carnival_mon,
  output logic [4:0]       goodfri_dom,
  output logic [2:0]       goodfri_mon,
  output logic [4:0]       ascension_dom,
  output logic [2:0]       ascension_mon,
  output logic [4:0]       whitsun_dom,
  output logic [2:0]       whitsun_mon,
  output logic             year_ok
);
  import emf_pkg::*;

  logic [NSTG-1:0] vld;
  logic            adv;

  // stage 1
  logic [13:0] s1_y;
  logic [26:0] s1_p100;
  logic [29:0] s1_p19;
  // stage 2
  logic [4:0]  s2_a;
  logic [7:0]  s2_b;
  logic [6:0]  s2_c;
  logic        s2_leap, s2_ok;
  // stage 3
  logic [8:0]  s3_a19;
  logic [2:0]  s3_f;
  logic [4:0]  s3_a;
  logic [7:0]  s3_b;
  logic [6:0]  s3_c;
  logic        s3_leap, s3_ok;
  // stage 4
  logic [5:0]  s4_g;
  logic [8:0]  s4_a19;
  logic [4:0]  s4_a;
  logic [7:0]  s4_b;
  logic [6:0]  s4_c;
  logic        s4_leap, s4_ok;
  // stage 5
  logic [11:0] s5_hx;
  logic [4:0]  s5_a;
  logic [1:0]  s5_e;
  logic [6:0]  s5_c;
  logic        s5_leap, s5_ok;
  // stage 6
  logic [6:0]  s6_qh;
  logic [11:0] s6_hx;
  logic [4:0]  s6_a;
  logic [1:0]  s6_e;
  logic [6:0]  s6_c;
  logic        s6_leap, s6_ok;
  // stage 7
  logic [4:0]  s7_h;
  logic [4:0]  s7_a;
  logic [1:0]  s7_e;
  logic [6:0]  s7_c;
  logic        s7_leap, s7_ok;
  // stage 8
  logic [6:0]  s8_lx;
  logic [8:0]  s8_h11;
  logic [4:0]  s8_h;
  logic [4:0]  s8_a;
  logic        s8_leap, s8_ok;
  // stage 9
  logic [4:0]  s9_ql;
  logic [6:0]  s9_lx;
  logic [8:0]  s9_h11;
  logic [4:0]  s9_h;
  logic [4:0]  s9_a;
  logic        s9_leap, s9_ok;
  // stage 10
  logic [2:0]  s10_l;
  logic [8:0]  s10_h11;
  logic [4:0]  s10_h;
  logic [4:0]  s10_a;
  logic        s10_leap, s10_ok;
  // stage 11
  logic        s11_m;
  logic [2:0]  s11_l;
  logic [4:0]  s11_h;
  logic        s11_leap, s11_ok;
  // stage 12
  logic [7:0]  s12_base;
  logic        s12_leap, s12_ok;
  // stage 13
  logic [4:0]  s13_ed;
  logic        s13_em4;
  logic        s13_leap, s13_ok;
  // stage 14
  logic [7:0]  s14_doy;
  logic [4:0]  s14_ed;
  logic        s14_em4;
  logic        s14_leap, s14_ok;
  // stage 15
  logic [7:0]  s15_car, s15_gf, s15_asc, s15_wh;
  logic [4:0]  s15_ed;
  logic        s15_em4;
  logic        s15_leap, s15_ok;

  // combinational helpers
  logic [7:0]  b2;
  logic [9:0]  q19;
  logic [13:0] a2w, c2w;
  logic [6:0]  c2;
  logic [12:0] fp;
  logic [7:0]  gn;
  logic [14:0] gp;
  logic [22:0] hp;
  logic [11:0] hw;
  logic [14:0] lp;
  logic [6:0]  lw;
  logic [8:0]  mx;
  logic        em4;
  date_t       d_car, d_gf, d_asc, d_wh;

  assign adv      = !vld[NSTG-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NSTG-1];

  always_comb begin
    b2  = s1_p100[26:19];
    q19 = s1_p19[29:20];
    a2w = s1_y - 14'(q19) * 14'd19;
    c2w = s1_y - 14'(b2) * 14'd100;
    c2  = c2w[6:0];
    fp  = (13'(s2_b) + 13'd8) * 13'd41;
    gn  = s3_b - 8'(s3_f) + 8'd1;
    gp  = 15'(gn) * 15'd171;
    hp  = 23'(s5_hx) * 23'd2185;
    hw  = s6_hx - 12'(s6_qh) * 12'd30;
    lp  = 15'(s8_lx) * 15'd147;
    lw  = s9_lx - 7'(s9_ql) * 7'd7;
    mx  = 9'(s10_a) + s10_h11 + 9'(s10_l) * 9'd22;
    em4 = s12_base >= 8'd124;
    d_car = date_of(s15_car, s15_leap);
    d_gf  = date_of(s15_gf, s15_leap);
    d_asc = date_of(s15_asc, s15_leap);
    d_wh  = date_of(s15_wh, s15_leap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // quotients by 100 and 19 through reciprocal multiplies
      s1_y    <= year;
      s1_p100 <= 27'(year) * 27'd5243;
      s1_p19  <= 30'(year) * 30'd55189;

      s2_a    <= a2w[4:0];
      s2_b    <= b2;
      s2_c    <= c2;
      s2_leap <= ((s1_y[1:0] == 2'd0) && (c2 != 7'd0)) || ((c2 == 7'd0) && (b2[1:0] == 2'd0));
      s2_ok   <= (s1_y >= YEAR_MIN) && (s1_y <= YEAR_MAX);

      s3_a19  <= 9'(s2_a) * 9'd19;
      s3_f    <= fp[12:10];
      s3_a    <= s2_a;
      s3_b    <= s2_b;
      s3_c    <= s2_c;
      s3_leap <= s2_leap;
      s3_ok   <= s2_ok;

      s4_g    <= gp[14:9];
      s4_a19  <= s3_a19;
      s4_a    <= s3_a;
      s4_b    <= s3_b;
      s4_c    <= s3_c;
      s4_leap <= s3_leap;
      s4_ok   <= s3_ok;

      // 15 + 60*30 folded into one constant
      s5_hx   <= 12'(s4_a19) + 12'(s4_b) + 12'd1815 - 12'(s4_b[7:2]) - 12'(s4_g);
      s5_a    <= s4_a;
      s5_e    <= s4_b[1:0];
      s5_c    <= s4_c;
      s5_leap <= s4_leap;
      s5_ok   <= s4_ok;

      s6_qh   <= hp[22:16];
      s6_hx   <= s5_hx;
      s6_a    <= s5_a;
      s6_e    <= s5_e;
      s6_c    <= s5_c;
      s6_leap <= s5_leap;
      s6_ok   <= s5_ok;

      s7_h    <= hw[4:0];
      s7_a    <= s6_a;
      s7_e    <= s6_e;
      s7_c    <= s6_c;
      s7_leap <= s6_leap;
      s7_ok   <= s6_ok;

      s8_lx   <= 7'd67 + 7'({s7_e, 1'b0}) + 7'({s7_c[6:2], 1'b0}) - 7'(s7_h) - 7'(s7_c[1:0]);
      s8_h11  <= 9'(s7_h) * 9'd11;
      s8_h    <= s7_h;
      s8_a    <= s7_a;
      s8_leap <= s7_leap;
      s8_ok   <= s7_ok;

      s9_ql   <= lp[14:10];
      s9_lx   <= s8_lx;
      s9_h11  <= s8_h11;
      s9_h    <= s8_h;
      s9_a    <= s8_a;
      s9_leap <= s8_leap;
      s9_ok   <= s8_ok;

      s10_l    <= lw[2:0];
      s10_h11  <= s9_h11;
      s10_h    <= s9_h;
      s10_a    <= s9_a;
      s10_leap <= s9_leap;
      s10_ok   <= s9_ok;

      // the quotient by 451 is at most one
      s11_m    <= mx >= 9'd451;
      s11_l    <= s10_l;
      s11_h    <= s10_h;
      s11_leap <= s10_leap;
      s11_ok   <= s10_ok;

      s12_base <= 8'(s11_h) + 8'(s11_l) + 8'd114 - (s11_m ? 8'd7 : 8'd0);
      s12_leap <= s11_leap;
      s12_ok   <= s11_ok;

      // month is 3 or 4 for every valid base
      s13_em4  <= em4;
      s13_ed   <= 5'(s12_base - (em4 ? 8'd123 : 8'd92));
      s13_leap <= s12_leap;
      s13_ok   <= s12_ok;

      s14_doy  <= 8'(s13_ed) + 8'd59 + 8'(s13_leap) + (s13_em4 ? 8'd31 : 8'd0);
      s14_ed   <= s13_ed;
      s14_em4  <= s13_em4;
      s14_leap <= s13_leap;
      s14_ok   <= s13_ok;

      s15_car  <= s14_doy - 8'd49;
      s15_gf   <= s14_doy - 8'd2;
      s15_asc  <= s14_doy + 8'd39;
      s15_wh   <= s14_doy + 8'd49;
      s15_ed   <= s14_ed;
      s15_em4  <= s14_em4;
      s15_leap <= s14_leap;
      s15_ok   <= s14_ok;

      // output register; clear every date of an out-of-range year
      leap          <= s15_leap;
      year_ok       <= s15_ok;
      easter_dom    <= s15_ok ? s15_ed : 5'd0;
      easter_mon    <= s15_ok ? (s15_em4 ? 3'd4 : 3'd3) : 3'd0;
      carnival_dom  <= s15_ok ? d_car.dom : 5'd0;
      carnival_mon  <= s15_ok ? d_car.mon[1:0] : 2'd0;
      goodfri_dom   <= s15_ok ? d_gf.dom : 5'd0;
      goodfri_mon   <= s15_ok ? d_gf.mon : 3'd0;
      ascension_dom <= s15_ok ? d_asc.dom : 5'd0;
      ascension_mon <= s15_ok ? d_asc.mon : 3'd0;
      whitsun_dom   <= s15_ok ? d_wh.dom : 5'd0;
      whitsun_mon   <= s15_ok ? d_wh.mon : 3'd0;
    end
  end

  a_stall_holds_valids: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_bad_year_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !year_ok |-> easter_dom == 5'd0 && easter_mon == 3'd0 &&
      carnival_mon == 2'd0 && whitsun_mon == 3'd0 && ascension_dom == 5'd0)
    else $error("dates not cleared for an out-of-range year");

  a_easter_month: assert property (@(posedge clk) disable iff (rst)
    out_valid && year_ok |-> (easter_mon == 3'd3 || easter_mon == 3'd4) &&
      (whitsun_mon == 3'd5 || whitsun_mon == 3'd6))
    else $error("feast month outside its season");

endmodule

`default_nettype wire
